// ===== rtl/sgr_pkg.sv =====
package sgr_pkg;

    // Width of the group size register and of the result value field.
    localparam int GS_W    = 7;
    localparam int VALUE_W = 32;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register index taken from paddr[2].
    localparam logic REG_GROUP_SIZE = 1'b0;

    localparam logic [GS_W-1:0] GROUP_SIZE_RESET = 7'd1;

    typedef struct packed {
        logic               list_last;
        logic               run_last;
        logic [VALUE_W-1:0] value;
    } result_t;

endpackage

// ===== rtl/sgr_ram.sv =====
module sgr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/stream_group_reverser.sv =====
// Stream group reverser.
// Elements enter on the s_ stream, one per transaction, with s_tlast marking
// the final element of a list. They are held in a single-port-read RAM until
// the current group holds group_size elements, and the group is then sent on
// the m_ stream in reverse order. A list that ends on a partial group has that
// group sent in its original order. m_tlast marks the last result caused by
// one input transaction and m_tuser flags the final element of the list.
// group_size is to be written through the APB port only while the block is
// idle; the block does not enforce this. An element that completes no group
// is stored and leaves the input ready. One that releases n results starts a
// drain of n RAM reads, one per cycle while the queue has room, with no input
// taken; each result passes the registered RAM read before the output queue.
// A two-entry result queue sits on the output, so reads are only issued when
// a slot is guaranteed; a stalled receiver simply pauses the drain and no
// result is dropped. Reset empties the group, clears the queue and sets the
// group size to one. The RAM needs no clearing pass after reset.
module stream_group_reverser #(
    parameter int MAX_GROUP  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [31:0] element_value
    input  logic                          s_tlast,   // list_end

    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // [31:0] out_value
    output logic                          m_tlast,   // run_last
    output logic [0:0]                    m_tuser,   // [0] list_last

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sgr_pkg::APB_AW-1:0]    paddr,
    input  logic [sgr_pkg::APB_DW-1:0]    pwdata,
    output logic [sgr_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int EW = DATA_WIDTH + sgr_pkg::VALUE_W;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    state_t                    state_reg;
    logic [sgr_pkg::GS_W-1:0]  group_size_reg;
    logic [AW-1:0]             fill_count_reg;

    logic [CW-1:0]             drain_n_reg;
    logic [CW-1:0]             drain_i_reg;
    logic                      drain_rev_reg;
    logic                      drain_end_reg;

    logic                      rd_valid_reg;
    logic                      rd_run_last_reg;
    logic                      rd_list_last_reg;

    sgr_pkg::result_t          queue_reg [2];
    logic                      wr_ptr_reg;
    logic                      rd_ptr_reg;
    logic [1:0]                count_reg;

    logic                      accept;
    logic                      pop;
    logic                      issue;
    logic                      issue_last;
    logic [CW-1:0]             k_eff;
    logic [CW-1:0]             n_fill;
    logic                      group_full;
    logic [CW-1:0]             rd_idx;
    logic [2:0]                slots_used;
    logic                      cfg_write;

    logic [EW-1:0]             wide_in;
    logic [EW-1:0]             wide_rd;
    logic [DATA_WIDTH-1:0]     ram_rdata;
    sgr_pkg::result_t          push_item;

    // Effective group size: zero counts as one, large values saturate.
    always_comb begin
        if (group_size_reg == '0) begin
            k_eff = CW'(1);
        end else if (group_size_reg > sgr_pkg::GS_W'(MAX_GROUP)) begin
            k_eff = CW'(MAX_GROUP);
        end else begin
            k_eff = CW'(group_size_reg);
        end
    end

    assign n_fill     = CW'(fill_count_reg) + CW'(1);
    assign group_full = (n_fill >= k_eff);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    // A read is only issued when its result is sure to find a queue slot.
    assign slots_used = 3'(count_reg) + 3'(rd_valid_reg);
    assign issue      = (state_reg == ST_DRAIN) &&
                        ((slots_used < 3'd2) || ((slots_used == 3'd2) && pop));
    assign issue_last = (drain_i_reg == drain_n_reg - CW'(1));
    assign rd_idx     = drain_rev_reg ? (drain_n_reg - CW'(1) - drain_i_reg) : drain_i_reg;

    assign wide_in = EW'(s_tdata);

    sgr_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_GROUP)
    ) u_group_ram (
        .clk   (aclk),
        .we    (accept),
        .waddr (fill_count_reg),
        .wdata (wide_in[DATA_WIDTH-1:0]),
        .re    (issue),
        .raddr (rd_idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign wide_rd             = EW'(ram_rdata);
    assign push_item.value     = wide_rd[sgr_pkg::VALUE_W-1:0];
    assign push_item.run_last  = rd_run_last_reg;
    assign push_item.list_last = rd_list_last_reg;

    assign m_tvalid   = (count_reg != 2'd0);
    assign m_tdata    = queue_reg[rd_ptr_reg].value;
    assign m_tlast    = queue_reg[rd_ptr_reg].run_last;
    assign m_tuser[0] = queue_reg[rd_ptr_reg].list_last;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == sgr_pkg::REG_GROUP_SIZE) ?
                       sgr_pkg::APB_DW'(group_size_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            group_size_reg <= sgr_pkg::GROUP_SIZE_RESET;
            fill_count_reg <= '0;
            rd_valid_reg   <= 1'b0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            count_reg      <= 2'd0;
        end else begin
            if (cfg_write && (paddr[2] == sgr_pkg::REG_GROUP_SIZE)) begin
                group_size_reg <= pwdata[sgr_pkg::GS_W-1:0];
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        drain_n_reg   <= n_fill;
                        drain_i_reg   <= '0;
                        drain_rev_reg <= group_full;
                        drain_end_reg <= s_tlast;
                        if (group_full || s_tlast) begin
                            fill_count_reg <= '0;
                            state_reg      <= ST_DRAIN;
                        end else begin
                            fill_count_reg <= n_fill[AW-1:0];
                        end
                    end
                end
                ST_DRAIN: begin
                    if (issue) begin
                        drain_i_reg <= drain_i_reg + CW'(1);
                        if (issue_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            rd_valid_reg <= issue;
            if (issue) begin
                rd_run_last_reg  <= issue_last;
                rd_list_last_reg <= issue_last && drain_end_reg;
            end

            if (rd_valid_reg) begin
                queue_reg[wr_ptr_reg] <= push_item;
                wr_ptr_reg            <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (rd_valid_reg && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (!rd_valid_reg && pop) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== tb/group_reverse_checker.sv =====
`timescale 1ns / 1ps

module group_reverse_checker #(
    parameter int MAX_GROUP = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [31:0]                s_tdata,   // [31:0] element_value
    input  logic                       s_tlast,   // list_end

    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [31:0]                m_tdata,   // [31:0] out_value
    input  logic                       m_tlast,   // run_last
    input  logic [0:0]                 m_tuser,   // [0] list_last

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sgr_pkg::APB_AW-1:0] paddr,
    input  logic [sgr_pkg::APB_DW-1:0] pwdata,
    input  logic                       pready,

    output int                         error_count,
    output int                         pending_count,
    output int                         results_checked
);

    logic [sgr_pkg::VALUE_W-1:0] held_values [MAX_GROUP];
    int unsigned                 held_count;
    logic [sgr_pkg::GS_W-1:0]    group_size;
    sgr_pkg::result_t            reordered_q [$];

    function automatic int unsigned effective_group(input logic [sgr_pkg::GS_W-1:0] gs);
        if (gs == 0) begin
            return 1;
        end
        if (gs > MAX_GROUP) begin
            return MAX_GROUP;
        end
        return gs;
    endfunction

    // Adds one element to the held group and queues whatever it releases.
    task automatic take_element(input logic [sgr_pkg::VALUE_W-1:0] value,
                                input logic list_end);
        int unsigned      k;
        int unsigned      n;
        int               i;
        sgr_pkg::result_t r;
        k = effective_group(group_size);
        held_values[held_count] = value;
        n = held_count + 1;
        if (n >= k) begin
            // A lowered size may leave more than k held: all go out as one group.
            for (i = 0; i < n; i++) begin
                r.value     = held_values[n - 1 - i];
                r.run_last  = (i == n - 1);
                r.list_last = (i == n - 1) && list_end;
                reordered_q = {reordered_q, r};
            end
            held_count = 0;
        end else if (list_end) begin
            for (i = 0; i < n; i++) begin
                r.value     = held_values[i];
                r.run_last  = (i == n - 1);
                r.list_last = (i == n - 1);
                reordered_q = {reordered_q, r};
            end
            held_count = 0;
        end else begin
            held_count = n;
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at %0t, result %0d: %s got %h, expected %h",
                 $realtime, results_checked, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        sgr_pkg::result_t r;
        if (!aresetn) begin
            reordered_q.delete();
            held_count      = 0;
            group_size      = sgr_pkg::GROUP_SIZE_RESET;
            error_count     = 0;
            results_checked = 0;
        end else begin
            if (psel && penable && pwrite && pready &&
                paddr[2] == sgr_pkg::REG_GROUP_SIZE) begin
                group_size = pwdata[sgr_pkg::GS_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                take_element(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (reordered_q.size() == 0) begin
                    flag_mismatch("transaction with nothing expected, data", m_tdata, 32'h0);
                end else begin
                    r = reordered_q.pop_front();
                    if (m_tdata !== r.value) begin
                        flag_mismatch("out_value", m_tdata, r.value);
                    end
                    if (m_tlast !== r.run_last) begin
                        flag_mismatch("run_last", {31'b0, m_tlast}, {31'b0, r.run_last});
                    end
                    if (m_tuser[0] !== r.list_last) begin
                        flag_mismatch("list_last", {31'b0, m_tuser[0]}, {31'b0, r.list_last});
                    end
                end
                results_checked++;
            end
        end
        pending_count = reordered_q.size();
    end

endmodule

// ===== tb/tb_stream_group_reverser.sv =====
`timescale 1ns / 1ps

module tb_stream_group_reverser;

    localparam int RANDOM_ELEMENTS = 230;
    localparam int CALM_AFTER      = 185;
    localparam int CYCLE_LIMIT     = 300000;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [31:0]                  s_tdata;
    logic                         s_tlast;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [31:0]                  m_tdata;
    logic                         m_tlast;
    logic [0:0]                   m_tuser;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [sgr_pkg::APB_AW-1:0]   paddr;
    logic [sgr_pkg::APB_DW-1:0]   pwdata;
    logic [sgr_pkg::APB_DW-1:0]   prdata;
    logic                         pready;

    int  error_count;
    int  pending_count;
    int  results_checked;
    int  cycle_count;
    int  elements_sent;
    int  lists_ended;
    int  size_writes;
    bit  calm;

    stream_group_reverser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    group_reverse_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .error_count     (error_count),
        .pending_count   (pending_count),
        .results_checked (results_checked)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, pending_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver back-pressure: stall bursts mixed with long ready stretches.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(0, 30)) @(negedge aclk);
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_element(input logic [31:0] value, input logic list_end);
        if (!calm && $urandom_range(0, 4) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= list_end;
        do @(posedge aclk); while (!s_tready);
        elements_sent++;
        if (list_end) begin
            lists_ended++;
        end
    endtask

    // Holds the sender off until every expected result is out and the block
    // has had time to finish any element that released nothing.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_group_size(input logic [sgr_pkg::GS_W-1:0] gs);
        logic [sgr_pkg::APB_DW-1:0] word;
        word                    = $urandom();
        word[sgr_pkg::GS_W-1:0] = gs;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sgr_pkg::REG_GROUP_SIZE, 2'b00};
        pwdata  <= word;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_writes++;
    endtask

    initial begin
        logic [sgr_pkg::GS_W-1:0] gs;
        int                       k;
        int                       len;
        int                       lists;
        int                       big_phases;
        int                       i;
        int                       j;
        bit                       open_end;

        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        elements_sent = 0;
        lists_ended   = 0;
        size_writes   = 0;
        big_phases    = 0;
        calm          = 1'b0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset group size of one: every element comes straight back.
        send_element(32'h8000_0000, 1'b0);
        send_element(32'h7FFF_FFFF, 1'b1);
        send_element(32'hFFFF_FFFF, 1'b0);

        // A size of zero behaves as one.
        settle();
        write_group_size(7'd0);
        send_element(32'h0000_0000, 1'b0);
        send_element(32'h1234_5678, 1'b1);

        // Full group reversed, group ending on the list end, short tail in order.
        settle();
        write_group_size(7'd3);
        for (i = 0; i < 3; i++) send_element(pick_value(), 1'b0);
        for (i = 0; i < 3; i++) send_element(pick_value(), i == 2);
        for (i = 0; i < 2; i++) send_element(pick_value(), i == 1);

        // Size lowered while a group is half full: everything held goes out.
        settle();
        write_group_size(7'd5);
        for (i = 0; i < 3; i++) send_element(pick_value(), 1'b0);
        settle();
        write_group_size(7'd2);
        send_element(pick_value(), 1'b1);

        // Random phases: mostly well-formed lists at small sizes, now and then
        // an unfinished list left behind across a size change.
        elements_sent = 0;
        while (elements_sent < RANDOM_ELEMENTS) begin
            case ($urandom_range(0, 11))
                0: begin
                    if (big_phases < 2) begin
                        gs = (big_phases == 0) ? 7'd64 : 7'($urandom_range(65, 127));
                        big_phases++;
                    end else begin
                        gs = 7'd1;
                    end
                end
                1:       gs = 7'd0;
                2:       gs = 7'd127;
                default: gs = 7'($urandom_range(1, 8));
            endcase
            k = (gs == 0) ? 1 : ((gs > 64) ? 64 : gs);
            settle();
            write_group_size(gs);
            lists = (k > 8) ? 1 : $urandom_range(1, 4);
            for (j = 0; j < lists; j++) begin
                len      = (k > 8) ? $urandom_range(k - 6, k + 6) : $urandom_range(1, 3 * k);
                open_end = (j == lists - 1) && ($urandom_range(0, 2) == 0);
                for (i = 0; (i < len) && (elements_sent < RANDOM_ELEMENTS); i++) begin
                    if (elements_sent >= CALM_AFTER) begin
                        calm = 1'b1;
                    end
                    send_element(pick_value(), (i == len - 1) && !open_end);
                end
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);

        $display("run covered %0d random elements after the directed part, %0d lists ended,",
                 elements_sent, lists_ended);
        $display("%0d group size writes and %0d results checked", size_writes,
                 results_checked);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
